// ----- hdl/plit_pkg.sv -----
package plit_pkg;

	localparam int MAX_POINTS = 64;
	localparam int VALUE_W    = 32;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int NP_W       = IDX_W + 1;
	localparam int DX_W       = VALUE_W + 1;
	localparam int PROD_W     = 2 * VALUE_W + 1;
	localparam int CNT_W      = $clog2(PROD_W + 1);
	localparam int ENTRY_W    = 2 * VALUE_W;

	localparam logic [NP_W-1:0] NP_RESET = NP_W'(2);
	localparam logic [NP_W-1:0] NP_MIN   = NP_W'(2);
	localparam logic [NP_W-1:0] NP_MAX   = NP_W'(MAX_POINTS);

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	// one table entry: x in the upper half, y in the lower
	typedef struct packed {
		logic signed [VALUE_W-1:0] x;
		logic signed [VALUE_W-1:0] y;
	} entry_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [VALUE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DX_W-1:0]  quotient;
	} div_rsp_t;

endpackage

// ----- hdl/plit_if.sv -----
interface plit_req_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  cmd;
	logic [plit_pkg::IDX_W-1:0]            point_index;
	logic signed [plit_pkg::VALUE_W-1:0]   x_value;
	logic signed [plit_pkg::VALUE_W-1:0]   y_value;

	modport source (output valid, cmd, point_index, x_value, y_value, input ready);
	modport sink   (input valid, cmd, point_index, x_value, y_value, output ready);
endinterface

interface plit_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [plit_pkg::VALUE_W-1:0]   y_result;
	logic                                  out_of_range;

	modport source (output valid, y_result, out_of_range, input ready);
	modport sink   (input valid, y_result, out_of_range, output ready);
endinterface

// ----- hdl/plit_ram.sv -----
module plit_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/plit_div.sv -----
// restoring divider, one quotient bit per cycle over the full product width
module plit_div (
	input  logic                clk,
	input  logic                arst_n,
	input  plit_pkg::div_req_t  req,
	output plit_pkg::div_rsp_t  rsp
);

	logic [plit_pkg::PROD_W-1:0]  dvd_q;
	logic [plit_pkg::VALUE_W-1:0] rem_q;
	logic [plit_pkg::VALUE_W-1:0] dsr_q;
	logic [plit_pkg::CNT_W-1:0]   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [plit_pkg::VALUE_W:0]   part;
	logic [plit_pkg::VALUE_W:0]   trial;
	logic                         fits;

	assign part  = {rem_q, dvd_q[plit_pkg::PROD_W-1]};
	assign trial = part - {1'b0, dsr_q};
	assign fits  = ~trial[plit_pkg::VALUE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= plit_pkg::CNT_W'(plit_pkg::PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == plit_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial[plit_pkg::VALUE_W-1:0] : part[plit_pkg::VALUE_W-1:0];
			dvd_q <= {dvd_q[plit_pkg::PROD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q[plit_pkg::DX_W-1:0];

endmodule

// ----- hdl/piecewise_linear_table_interp.sv -----
// channel  dir  payload                                     notes
// req      in   cmd, point_index, x_value, y_value          load or query word
// rsp      out  y_result, out_of_range                      one word per query
// cfg      in   cfg_we, cfg_wdata (num_points)              write only, when idle
//
// A load is written when accepted. A query passes the accept state, reads of the last
// and then the first entry, a read and a check per entry scanned (s = 1 .. num_points-1)
// over the single RAM read port, then segment, multiply, divider start, the divide and
// finish states; a query outside the span goes from the first-entry check to finish.
// arst_n clears control state and sets num_points to 2; table contents stay undefined
// until loaded. A query may start while a result still waits in the output register;
// it then holds in the finish state until rsp is taken.
module piecewise_linear_table_interp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [plit_pkg::NP_W-1:0]   cfg_wdata,
	plit_req_if.sink                    req,
	plit_rsp_if.source                  rsp
);

	typedef enum logic [3:0] {
		S_IDLE, S_RD_LAST, S_CHK_LAST, S_RD_FIRST, S_CHK_FIRST,
		S_RD_SCAN, S_CHK_SCAN, S_SEG, S_MUL, S_DIV_GO, S_DIV, S_FIN
	} state_t;

	state_t                              state_q;
	logic [plit_pkg::NP_W-1:0]           num_points_q;
	logic [plit_pkg::NP_W-1:0]           n_eff;
	logic [plit_pkg::IDX_W-1:0]          last_idx;
	logic [plit_pkg::IDX_W-1:0]          j_q;
	logic [plit_pkg::IDX_W-1:0]          raddr;
	logic                                ram_we;
	plit_pkg::entry_t                    wentry;
	plit_pkg::entry_t                    rentry;
	logic signed [plit_pkg::VALUE_W-1:0] xq_q;
	logic signed [plit_pkg::VALUE_W-1:0] x0_q, y0_q, x1_q, y1_q;
	logic signed [plit_pkg::DX_W-1:0]    dx, dy;
	logic [plit_pkg::DX_W-1:0]           mag;
	logic [plit_pkg::VALUE_W-1:0]        t;
	logic [plit_pkg::VALUE_W-1:0]        dx_q;
	logic [plit_pkg::VALUE_W-1:0]        t_q;
	logic [plit_pkg::DX_W-1:0]           mag_q;
	logic                                neg_q;
	logic [plit_pkg::PROD_W-1:0]         prod_s1;
	logic signed [plit_pkg::VALUE_W-1:0] res_q;
	logic                                oor_q;
	logic                                out_valid_q;
	logic signed [plit_pkg::VALUE_W-1:0] out_y_q;
	logic                                out_oor_q;
	logic [plit_pkg::DX_W-1:0]           y0_ext;
	logic [plit_pkg::DX_W-1:0]           sum;
	plit_pkg::div_req_t                  dreq;
	plit_pkg::div_rsp_t                  drsp;

	always_comb begin
		if (num_points_q < plit_pkg::NP_MIN) begin
			n_eff = plit_pkg::NP_MIN;
		end else if (num_points_q > plit_pkg::NP_MAX) begin
			n_eff = plit_pkg::NP_MAX;
		end else begin
			n_eff = num_points_q;
		end
	end
	assign last_idx = plit_pkg::IDX_W'(n_eff - 1'b1);

	always_comb begin
		case (state_q)
			S_RD_LAST: raddr = last_idx;
			S_RD_SCAN: raddr = j_q;
			default:   raddr = '0;
		endcase
	end

	assign req.ready = (state_q == S_IDLE);
	assign ram_we    = req.valid && req.ready && (req.cmd == plit_pkg::CMD_LOAD);
	assign wentry.x  = req.x_value;
	assign wentry.y  = req.y_value;

	plit_ram #(
		.WIDTH(plit_pkg::ENTRY_W),
		.DEPTH(plit_pkg::MAX_POINTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (req.point_index),
		.wdata (wentry),
		.raddr (raddr),
		.rdata (rentry)
	);

	assign dx  = {x1_q[plit_pkg::VALUE_W-1], x1_q} - {x0_q[plit_pkg::VALUE_W-1], x0_q};
	assign dy  = {y1_q[plit_pkg::VALUE_W-1], y1_q} - {y0_q[plit_pkg::VALUE_W-1], y0_q};
	assign mag = dy[plit_pkg::DX_W-1] ? plit_pkg::DX_W'(-dy) : plit_pkg::DX_W'(dy);
	// query lies at or above x[k], at most dx above: fits unsigned
	assign t   = plit_pkg::VALUE_W'(xq_q - x0_q);

	// product registered in S_MUL, divider loads it in S_DIV_GO, the state after
	assign dreq.start    = (state_q == S_DIV_GO);
	assign dreq.dividend = prod_s1;
	assign dreq.divisor  = dx_q;

	plit_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign y0_ext = {y0_q[plit_pkg::VALUE_W-1], y0_q};
	assign sum    = neg_q ? (y0_ext - drsp.quotient) : (y0_ext + drsp.quotient);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			num_points_q <= plit_pkg::NP_RESET;
			out_valid_q  <= 1'b0;
			j_q          <= '0;
		end else begin
			if (cfg_we) begin
				num_points_q <= cfg_wdata;
			end
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.cmd == plit_pkg::CMD_QUERY) begin
						state_q <= S_RD_LAST;
					end
				end
				S_RD_LAST:  state_q <= S_CHK_LAST;
				S_CHK_LAST: state_q <= S_RD_FIRST;
				S_RD_FIRST: state_q <= S_CHK_FIRST;
				S_CHK_FIRST: begin
					j_q <= plit_pkg::IDX_W'(1);
					if (xq_q < rentry.x || xq_q > x1_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_RD_SCAN;
					end
				end
				S_RD_SCAN: state_q <= S_CHK_SCAN;
				S_CHK_SCAN: begin
					if (xq_q < rentry.x || j_q == last_idx) begin
						state_q <= S_SEG;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_RD_SCAN;
					end
				end
				S_SEG: begin
					if (dx[plit_pkg::DX_W-1] || dx == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL:    state_q <= S_DIV_GO;
				S_DIV_GO: state_q <= S_DIV;
				S_DIV: begin
					if (drsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				xq_q  <= req.x_value;
				oor_q <= 1'b1;
				res_q <= '0;
			end
			S_CHK_LAST: x1_q <= rentry.x;
			S_CHK_FIRST: begin
				x0_q <= rentry.x;
				y0_q <= rentry.y;
			end
			S_CHK_SCAN: begin
				x1_q <= rentry.x;
				y1_q <= rentry.y;
				if (!(xq_q < rentry.x) && j_q != last_idx) begin
					x0_q <= rentry.x;
					y0_q <= rentry.y;
				end
			end
			S_SEG: begin
				dx_q  <= dx[plit_pkg::VALUE_W-1:0];
				t_q   <= t;
				mag_q <= mag;
				neg_q <= dy[plit_pkg::DX_W-1];
			end
			S_MUL: ;
			S_DIV: begin
				if (drsp.done) begin
					res_q <= sum[plit_pkg::VALUE_W-1:0];
					oor_q <= 1'b0;
				end
			end
			S_FIN: begin
				if (!out_valid_q || rsp.ready) begin
					out_y_q   <= res_q;
					out_oor_q <= oor_q;
				end
			end
			default: ;
		endcase
		prod_s1 <= mag_q * t_q;
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.y_result     = out_y_q;
	assign rsp.out_of_range = out_oor_q;

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == S_IDLE)
		else $error("table written outside idle");

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && oor_q) |-> res_q == '0)
		else $error("flagged result not zero");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> state_q == S_DIV)
		else $error("divider finished outside divide state");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FIN)
		else $error("output word without finish");

endmodule
